// ----- hdl/kbh_pkg.sv -----
package kbh_pkg;

  localparam int HASH_W      = 32;
  localparam int INDEX_W     = 31;
  localparam int BYTE_W      = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [HASH_W-1:0] HASH_INIT = 32'd1;
  localparam logic [HASH_W-1:0] STEP_INIT = 32'd4;
  localparam logic [HASH_W-1:0] STEP_INC  = 32'd3;
  localparam logic [HASH_W-1:0] LOW6_MASK = 32'd63;

  typedef enum logic [0:0] {
    REG_BUCKET_SPAN  = 1'b0,
    REG_RECORD_COUNT = 1'b1
  } cfg_reg_t;

  // finished hash handed from the front to the queue
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } kbh_push_t;

  // head of the queue as seen by the back
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } kbh_head_t;

endpackage

// ----- hdl/kbh_if.sv -----
interface kbh_in_if import kbh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] key_byte;
  logic              null_segment;
  logic              last_byte;

  modport source (output valid, key_byte, null_segment, last_byte, input ready);
  modport sink (input valid, key_byte, null_segment, last_byte, output ready);
endinterface

interface kbh_out_if import kbh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [HASH_W-1:0]  hash_value;
  logic [INDEX_W-1:0] bucket_index;

  modport source (output valid, hash_value, bucket_index, input ready);
  modport sink (input valid, hash_value, bucket_index, output ready);
endinterface

interface kbh_cfg_if import kbh_pkg::*; ();
  logic              valid;
  logic              ready;
  cfg_reg_t          index;
  logic [HASH_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/kbh_front.sv -----
module kbh_front import kbh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  kbh_in_if.sink    keys,
  input  logic      queue_full,
  output kbh_push_t push
);

  logic [HASH_W-1:0] hash_acc;
  logic [HASH_W-1:0] step_acc;
  logic [HASH_W-1:0] hash_acc_next;
  logic [HASH_W-1:0] step_acc_next;
  logic [HASH_W-1:0] factor;
  logic [HASH_W-1:0] mix;
  logic              accept;

  assign keys.ready = !queue_full;
  assign accept     = keys.valid && keys.ready;

  assign factor = (hash_acc & LOW6_MASK) + step_acc;
  assign mix    = factor * {{(HASH_W-BYTE_W){1'b0}}, keys.key_byte} + (hash_acc << 8);

  always_comb begin
    if (keys.null_segment) begin
      hash_acc_next = hash_acc ^ ((hash_acc << 1) | HASH_W'(1));
      step_acc_next = step_acc;
    end else begin
      hash_acc_next = hash_acc ^ mix;
      step_acc_next = step_acc + STEP_INC;
    end
  end

  assign push.valid = accept && keys.last_byte;
  assign push.hash  = hash_acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_acc <= HASH_INIT;
      step_acc <= STEP_INIT;
    end else if (accept) begin
      if (keys.last_byte) begin
        hash_acc <= HASH_INIT;
        step_acc <= STEP_INIT;
      end else begin
        hash_acc <= hash_acc_next;
        step_acc <= step_acc_next;
      end
    end
  end

  a_reload: assert property (@(posedge clk) disable iff (rst)
    push.valid |=> (hash_acc == HASH_INIT) && (step_acc == STEP_INIT))
    else $error("accumulators not reloaded after last byte");

endmodule

// ----- hdl/kbh_queue.sv -----
module kbh_queue import kbh_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  kbh_push_t push,
  output logic      full,
  output kbh_head_t head,
  input  logic      take
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [HASH_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.hash  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.hash;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= bump(wr_ptr);
      if (take) rd_ptr <= bump(rd_ptr);
      if (push.valid && !take) count <= count + CNT_W'(1);
      else if (!push.valid && take) count <= count - CNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    take |-> head.valid)
    else $error("request taken from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push.valid && !take) |=> count == $past(count) + CNT_W'(1))
    else $error("queue count lost a request");

endmodule

// ----- hdl/kbh_back.sv -----
module kbh_back import kbh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  kbh_cfg_if.sink   cfg,
  input  kbh_head_t head,
  output logic      take,
  kbh_out_if.source results
);

  logic [HASH_W-1:0]  full_mask;
  logic [HASH_W-1:0]  half_mask;
  logic [HASH_W-1:0]  record_count;
  logic [HASH_W-1:0]  full_idx;
  logic [HASH_W-1:0]  sel_idx;
  logic               out_valid;
  logic [HASH_W-1:0]  out_hash;
  logic [INDEX_W-1:0] out_index;

  assign cfg.ready = 1'b1;

  // masks are formed at write time: span - 1 and span/2 - 1, wrapping
  always_ff @(posedge clk) begin
    if (rst) begin
      full_mask    <= '0;
      half_mask    <= '1;
      record_count <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BUCKET_SPAN: begin
          full_mask <= cfg.data - HASH_W'(1);
          half_mask <= (cfg.data >> 1) - HASH_W'(1);
        end
        REG_RECORD_COUNT: begin
          record_count <= cfg.data;
        end
      endcase
    end
  end

  assign full_idx = head.hash & full_mask;
  assign sel_idx  = (full_idx < record_count) ? full_idx : (head.hash & half_mask);
  assign take     = head.valid && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_hash  <= head.hash;
      out_index <= sel_idx[INDEX_W-1:0];
    end
  end

  assign results.valid        = out_valid;
  assign results.hash_value   = out_hash;
  assign results.bucket_index = out_index;

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("popped request did not reach output register");

endmodule

// ----- hdl/key_byte_hash_bucket_index.sv -----
// channel  | dir | handshake     | payload
// keys     | in  | valid/ready   | key_byte[7:0], null_segment, last_byte
// results  | out | valid/ready   | hash_value[31:0], bucket_index[30:0]
// cfg      | in  | valid/ready   | index (0 bucket_span, 1 record_count), data[31:0]
//
// One key item per cycle while keys.ready is high; the hash recurrence (one 32x8
// multiply, add, xor) is combinational in the front, registered in the accumulators.
// After its last byte is accepted, a result is written into the queue and, once the
// back takes it, into the output register, which drives results.valid.
// Reset (rst, synchronous) reloads the accumulators to 1 and 4, span 1, record count 0.
// keys.ready drops only while the hash queue is full; a held result stalls the back.
// cfg is always ready.
module key_byte_hash_bucket_index import kbh_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  kbh_in_if.sink    keys,
  kbh_out_if.source results,
  kbh_cfg_if.sink   cfg
);

  kbh_push_t push;
  kbh_head_t head;
  logic      queue_full;
  logic      take;

  kbh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .keys       (keys),
    .queue_full (queue_full),
    .push       (push)
  );

  kbh_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .head (head),
    .take (take)
  );

  kbh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .take    (take),
    .results (results)
  );

endmodule

// ----- dv/tb.sv -----
module tb;
  import kbh_pkg::*;

  localparam int N_DIRECTED   = 21;
  localparam int N_PHASES     = 11;
  localparam int PHASE_ITEMS  = 100;
  localparam int SETTLE       = 4;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_REPORTED = 10;
  localparam int TIMEOUT      = 4_000_000;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [INDEX_W-1:0] bucket;
  } hash_result_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  key_byte;
    logic               null_seg;
    logic               last;
    logic               pinned;
    logic [HASH_W-1:0]  hash;
    logic [INDEX_W-1:0] bucket;
  } key_row_t;

  // pinned rows assume the reset register values
  key_row_t directed_keys [N_DIRECTED] = '{
    '{8'h00, 1'b1, 1'b1, 1'b1, 32'd2,    31'd2},
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'd257,  31'd257},
    '{8'hFF, 1'b0, 1'b1, 1'b1, 32'd1530, 31'd1530},
    '{8'h80, 1'b0, 1'b0, 1'b0, 32'd0,    31'd0},
    '{8'h01, 1'b0, 1'b0, 1'b0, 32'd0,    31'd0},
    '{8'h55, 1'b0, 1'b0, 1'b0, 32'd0,    31'd0},
    '{8'hAA, 1'b0, 1'b1, 1'b0, 32'd0,    31'd0},
    '{8'h12, 1'b0, 1'b0, 1'b0, 32'd0,    31'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 32'd0,    31'd0},
    '{8'h34, 1'b0, 1'b1, 1'b0, 32'd0,    31'd0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 32'd0,    31'd0},
    '{8'h7F, 1'b1, 1'b1, 1'b0, 32'd0,    31'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0,    31'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0,    31'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0,    31'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0,    31'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0,    31'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0,    31'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0,    31'd0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 32'd0,    31'd0},
    '{8'h01, 1'b0, 1'b1, 1'b0, 32'd0,    31'd0}
  };

  logic [HASH_W-1:0] phase_span [N_PHASES] = '{
    32'd1, 32'd0, 32'h8000_0000, 32'd16, 32'd16, 32'hFFFF_FFFF,
    32'd1024, 32'd2, 32'd0, 32'd0, 32'h8000_0000
  };
  logic [HASH_W-1:0] phase_count [N_PHASES] = '{
    32'd0, 32'd0, 32'h8000_0000, 32'd10, 32'd16, 32'h0001_2345,
    32'd600, 32'd1, 32'd0, 32'd0, 32'd0
  };

  logic clk = 1'b0;
  logic rst;

  kbh_in_if  keys ();
  kbh_out_if results ();
  kbh_cfg_if cfg ();

  key_byte_hash_bucket_index i_dut (
    .clk     (clk),
    .rst     (rst),
    .keys    (keys),
    .results (results),
    .cfg     (cfg)
  );

  always #4 clk = ~clk;

  logic               pin_valid;
  logic [HASH_W-1:0]  pin_hash;
  logic [INDEX_W-1:0] pin_bucket;

  logic [HASH_W-1:0] span_reg;
  logic [HASH_W-1:0] count_reg;
  logic [HASH_W-1:0] key_hash;
  logic [HASH_W-1:0] key_step;
  hash_result_t      pending_results [$];
  int                mismatches = 0;
  bit                quiet = 1'b0;
  bit                hold_results = 1'b0;

  function automatic void mix_key_item(input logic [BYTE_W-1:0] b, input logic null_seg);
    logic [HASH_W-1:0] factor;
    if (null_seg) begin
      key_hash = key_hash ^ ((key_hash << 1) | HASH_W'(1));
    end else begin
      factor   = (key_hash & LOW6_MASK) + key_step;
      key_hash = key_hash ^ (factor * HASH_W'(b) + (key_hash << 8));
      key_step = key_step + STEP_INC;
    end
  endfunction

  function automatic logic [INDEX_W-1:0] bucket_for(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] full_mask;
    logic [HASH_W-1:0] half_mask;
    logic [HASH_W-1:0] full;
    full_mask = span_reg - HASH_W'(1);
    half_mask = (span_reg >> 1) - HASH_W'(1);
    full      = h & full_mask;
    if (full < count_reg) return full[INDEX_W-1:0];
    return h[INDEX_W-1:0] & half_mask[INDEX_W-1:0];
  endfunction

  function automatic void report_mismatch(input string what, input logic [HASH_W-1:0] exp_v,
                                          input logic [HASH_W-1:0] act_v);
    if (mismatches < MAX_REPORTED)
      $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, act_v);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    hash_result_t got;
    hash_result_t want;
    if (rst) begin
      span_reg  <= 32'd1;
      count_reg <= 32'd0;
      key_hash  = HASH_INIT;
      key_step  = STEP_INIT;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_BUCKET_SPAN) span_reg <= cfg.data;
        else if (cfg.index == REG_RECORD_COUNT) count_reg <= cfg.data;
      end
      if (keys.valid && keys.ready) begin
        mix_key_item(keys.key_byte, keys.null_segment);
        if (keys.last_byte) begin
          if (pin_valid) pending_results.push_back('{pin_hash, pin_bucket});
          else pending_results.push_back('{key_hash, bucket_for(key_hash)});
          key_hash = HASH_INIT;
          key_step = STEP_INIT;
        end
      end
      if (results.valid && results.ready) begin
        got = '{results.hash_value, results.bucket_index};
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result hash", '0, got.hash);
        end else begin
          want = pending_results.pop_front();
          if (got.hash != want.hash) report_mismatch("hash_value", want.hash, got.hash);
          if (got.bucket != want.bucket)
            report_mismatch("bucket_index", HASH_W'(want.bucket), HASH_W'(got.bucket));
        end
      end
    end
  end

  task automatic send_key_item(input logic [BYTE_W-1:0] b, input logic null_seg,
                               input logic last, input key_row_t pin);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      keys.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    keys.valid        <= 1'b1;
    keys.key_byte     <= b;
    keys.null_segment <= null_seg;
    keys.last_byte    <= last;
    pin_valid         <= pin.pinned;
    pin_hash          <= pin.hash;
    pin_bucket        <= pin.bucket;
    @(posedge clk);
    while (!keys.ready) @(posedge clk);
  endtask

  task automatic program_registers(input logic [HASH_W-1:0] span, input logic [HASH_W-1:0] cnt);
    cfg.valid <= 1'b1;
    cfg.index <= REG_BUCKET_SPAN;
    cfg.data  <= span;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.index <= REG_RECORD_COUNT;
    cfg.data  <= cnt;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // one edge first so that the last accepted request is already queued
  task automatic wait_drained();
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // receiver side: random back-pressure, one long hold-off on request
  initial begin
    int wait_cycles;
    results.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_results) begin
        results.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_results = 1'b0;
      end
      wait_cycles = quiet ? 0 : $urandom_range(0, 5);
      if (wait_cycles > 0) begin
        results.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      results.ready <= 1'b1;
      @(posedge clk);
      while (!results.valid) @(posedge clk);
    end
  end

  initial begin
    #(TIMEOUT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    key_row_t no_pin;
    int       key_len;
    int       sent;
    int       shift;
    no_pin            = '0;
    rst               <= 1'b1;
    keys.valid        <= 1'b0;
    keys.key_byte     <= '0;
    keys.null_segment <= 1'b0;
    keys.last_byte    <= 1'b0;
    cfg.valid         <= 1'b0;
    cfg.index         <= REG_BUCKET_SPAN;
    cfg.data          <= '0;
    pin_valid         <= 1'b0;
    pin_hash          <= '0;
    pin_bucket        <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECTED; r++)
      send_key_item(directed_keys[r].key_byte, directed_keys[r].null_seg,
                    directed_keys[r].last, directed_keys[r]);
    keys.valid <= 1'b0;
    pin_valid  <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      if (p == 8) begin
        shift          = $urandom_range(0, 31);
        phase_span[p]  = 32'd1 << shift;
        phase_count[p] = (phase_span[p] >> 1) + $urandom_range(0, phase_span[p] >> 1);
      end else if (p == 9) begin
        phase_span[p]  = $urandom;
        phase_count[p] = $urandom;
      end
      program_registers(phase_span[p], phase_count[p]);
      quiet = (p % 4 == 1);
      // fill the result queue so that keys.ready has to drop
      if (p == 3) hold_results = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        key_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        for (int k = 0; k < key_len; k++)
          send_key_item(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                        k == key_len - 1, no_pin);
        sent += key_len;
      end
      keys.valid <= 1'b0;
      quiet = 1'b0;
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/kbh_pkg.sv
hdl/kbh_if.sv
hdl/kbh_front.sv
hdl/kbh_queue.sv
hdl/kbh_back.sv
hdl/key_byte_hash_bucket_index.sv
dv/tb.sv
